/* sv/grb_pkg.sv */
// Shared constants, access codes and types for the GPIO register block.
`default_nettype none

package grb_pkg;

    localparam int PIN_COUNT_DEFAULT = 54;
    localparam int LEVEL_WIDTH       = 54;
    localparam int DATA_WIDTH        = 32;
    localparam int ADDR_WIDTH        = 4;
    localparam int FSEL_WORDS        = 6;
    localparam int PINS_PER_FSEL     = 10;
    localparam int FSEL_WIDTH        = 3 * PINS_PER_FSEL;
    localparam int PIN_SPACE         = 64;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [ADDR_WIDTH-1:0] ADDR_FSEL0  = 4'd0;
    localparam logic [ADDR_WIDTH-1:0] ADDR_FSEL1  = 4'd1;
    localparam logic [ADDR_WIDTH-1:0] ADDR_FSEL2  = 4'd2;
    localparam logic [ADDR_WIDTH-1:0] ADDR_FSEL3  = 4'd3;
    localparam logic [ADDR_WIDTH-1:0] ADDR_FSEL4  = 4'd4;
    localparam logic [ADDR_WIDTH-1:0] ADDR_FSEL5  = 4'd5;
    localparam logic [ADDR_WIDTH-1:0] ADDR_SET_LO = 4'd7;
    localparam logic [ADDR_WIDTH-1:0] ADDR_SET_HI = 4'd8;
    localparam logic [ADDR_WIDTH-1:0] ADDR_CLR_LO = 4'd10;
    localparam logic [ADDR_WIDTH-1:0] ADDR_CLR_HI = 4'd11;
    localparam logic [ADDR_WIDTH-1:0] ADDR_LEV_LO = 4'd13;
    localparam logic [ADDR_WIDTH-1:0] ADDR_LEV_HI = 4'd14;

    typedef struct packed {
        logic                   valid;
        logic                   command;
        logic [ADDR_WIDTH-1:0]  word_address;
        logic [DATA_WIDTH-1:0]  write_data;
        logic [LEVEL_WIDTH-1:0] pin_levels;
    } access_t;

    function automatic logic [FSEL_WIDTH-1:0] fsel_mask(input int pin_count, input int widx);
        logic [FSEL_WIDTH-1:0] m;
        m = '0;
        for (int f = 0; f < PINS_PER_FSEL; f++)
        begin
            if (widx * PINS_PER_FSEL + f < pin_count)
            begin
                m[3*f +: 3] = 3'b111;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* sv/grb_core.sv */
// Register file and access decode: function selects, output latch, level reads.
`default_nettype none

module grb_core #(
    parameter int PIN_COUNT = grb_pkg::PIN_COUNT_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire grb_pkg::access_t                   act,
    output logic [grb_pkg::DATA_WIDTH-1:0]          read_data_next,
    output logic [grb_pkg::LEVEL_WIDTH-1:0]         output_levels_next
);
    import grb_pkg::*;

    localparam logic [PIN_SPACE-1:0] PIN_MASK =
        (PIN_COUNT >= PIN_SPACE) ? {PIN_SPACE{1'b1}}
                                 : ((PIN_SPACE'(1) << PIN_COUNT) - PIN_SPACE'(1));

    logic [FSEL_WIDTH-1:0] fsel_mask_w [FSEL_WORDS];
    logic [FSEL_WIDTH-1:0] fsel_reg    [FSEL_WORDS];
    logic [FSEL_WIDTH-1:0] fsel_next   [FSEL_WORDS];
    logic [PIN_COUNT-1:0]  latch_reg;
    logic [PIN_COUNT-1:0]  latch_next;
    logic [PIN_SPACE-1:0]  spread;
    logic [PIN_SPACE-1:0]  levels;
    logic [PIN_SPACE-1:0]  latch_wide;
    logic [2:0]            fsel_idx;
    logic                  hi_half;
    logic                  is_write;

    for (genvar w = 0; w < FSEL_WORDS; w++)
    begin : g_mask
        assign fsel_mask_w[w] = fsel_mask(PIN_COUNT, w);
    end

    assign fsel_idx = act.word_address[2:0];
    assign is_write = (act.command == CMD_WRITE);
    assign hi_half  = (act.word_address == ADDR_SET_HI) || (act.word_address == ADDR_CLR_HI);
    assign spread   = hi_half ? {act.write_data, {DATA_WIDTH{1'b0}}}
                              : {{DATA_WIDTH{1'b0}}, act.write_data};
    assign levels   = PIN_SPACE'(act.pin_levels) & PIN_MASK;

    always_comb
    begin
        read_data_next = '0;
        fsel_next      = fsel_reg;
        latch_next     = latch_reg;
        if (act.valid)
        begin
            unique case (act.word_address)
                ADDR_FSEL0, ADDR_FSEL1, ADDR_FSEL2, ADDR_FSEL3, ADDR_FSEL4, ADDR_FSEL5:
                begin
                    if (is_write)
                        fsel_next[fsel_idx] = act.write_data[FSEL_WIDTH-1:0]
                                              & fsel_mask_w[fsel_idx];
                    else
                        read_data_next = DATA_WIDTH'(fsel_reg[fsel_idx] & fsel_mask_w[fsel_idx]);
                end
                ADDR_SET_LO, ADDR_SET_HI:
                begin
                    if (is_write)
                        latch_next = latch_reg | spread[PIN_COUNT-1:0];
                end
                ADDR_CLR_LO, ADDR_CLR_HI:
                begin
                    if (is_write)
                        latch_next = latch_reg & ~spread[PIN_COUNT-1:0];
                end
                ADDR_LEV_LO:
                begin
                    if (!is_write)
                        read_data_next = levels[DATA_WIDTH-1:0];
                end
                ADDR_LEV_HI:
                begin
                    if (!is_write)
                        read_data_next = levels[PIN_SPACE-1:DATA_WIDTH];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign latch_wide         = PIN_SPACE'(latch_next);
    assign output_levels_next = latch_wide[LEVEL_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < FSEL_WORDS; w++)
            begin
                fsel_reg[w] <= '0;
            end
            latch_reg <= '0;
        end
        else
        begin
            fsel_reg  <= fsel_next;
            latch_reg <= latch_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_read_keeps_latch: assert property (@(posedge clk) disable iff (!rst_n)
        act.valid && !is_write |=> $stable(latch_reg))
        else $error("read access changed the output latch");

    a_set_pin0: assert property (@(posedge clk) disable iff (!rst_n)
        act.valid && is_write && act.word_address == ADDR_SET_LO && act.write_data[0]
        |=> latch_reg[0])
        else $error("set of pin 0 not taken");

    a_clr_pin0: assert property (@(posedge clk) disable iff (!rst_n)
        act.valid && is_write && act.word_address == ADDR_CLR_LO && act.write_data[0]
        |=> !latch_reg[0])
        else $error("clear of pin 0 not taken");
`endif

endmodule

`default_nettype wire

/* sv/gpio_register_block.sv */
// An item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while out_stall is low; decode is combinational.
// Accepts a new item while a finished result waits, through the input register.
// Reset: rst_n, asynchronous, active low, clears the function selects,
// the output latch and all valid flags.
// Top level: input register, register file core, result register.
`default_nettype none

module gpio_register_block #(
    parameter int PIN_COUNT = grb_pkg::PIN_COUNT_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic [grb_pkg::ADDR_WIDTH-1:0]     word_address,
    input  wire logic [grb_pkg::DATA_WIDTH-1:0]     write_data,
    input  wire logic [grb_pkg::LEVEL_WIDTH-1:0]    pin_levels,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [grb_pkg::DATA_WIDTH-1:0]          read_data,
    output logic [grb_pkg::LEVEL_WIDTH-1:0]         output_levels
);
    import grb_pkg::*;

    logic                   s1_valid_reg;
    logic                   s1_command_reg;
    logic [ADDR_WIDTH-1:0]  s1_address_reg;
    logic [DATA_WIDTH-1:0]  s1_data_reg;
    logic [LEVEL_WIDTH-1:0] s1_levels_reg;
    logic                   out_valid_reg;
    logic [DATA_WIDTH-1:0]  read_data_reg;
    logic [LEVEL_WIDTH-1:0] output_levels_reg;
    logic [DATA_WIDTH-1:0]  read_data_next;
    logic [LEVEL_WIDTH-1:0] output_levels_next;
    logic                   advance;
    access_t                act;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    assign act.valid        = s1_valid_reg && advance;
    assign act.command      = s1_command_reg;
    assign act.word_address = s1_address_reg;
    assign act.write_data   = s1_data_reg;
    assign act.pin_levels   = s1_levels_reg;

    grb_core #(
        .PIN_COUNT(PIN_COUNT)
    ) u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .act                (act),
        .read_data_next     (read_data_next),
        .output_levels_next (output_levels_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_command_reg <= command;
            s1_address_reg <= word_address;
            s1_data_reg    <= write_data;
            s1_levels_reg  <= pin_levels;
        end
        if (act.valid)
        begin
            read_data_reg     <= read_data_next;
            output_levels_reg <= output_levels_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign output_levels = output_levels_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room to hold the item");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        act.valid |=> out_valid_reg)
        else $error("processed item produced no result");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while result register empty");
`endif

endmodule

`default_nettype wire

/* sim/gpio_register_block_test.sv */
// Testbench for gpio_register_block: directed and random bus accesses checked against a predictor.
`timescale 1ns / 1ps

module gpio_register_block_test;

    import grb_pkg::*;

    localparam int PIN_COUNT = PIN_COUNT_DEFAULT;

    localparam logic [ADDR_WIDTH-1:0] ADDR_GAP_FSEL = 4'd6;
    localparam logic [ADDR_WIDTH-1:0] ADDR_GAP_SET  = 4'd9;
    localparam logic [ADDR_WIDTH-1:0] ADDR_GAP_CLR  = 4'd12;
    localparam logic [ADDR_WIDTH-1:0] ADDR_GAP_LEV  = 4'd15;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]  read_data;
        logic [LEVEL_WIDTH-1:0] output_levels;
    } gpio_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   command;
    logic [ADDR_WIDTH-1:0]  word_address;
    logic [DATA_WIDTH-1:0]  write_data;
    logic [LEVEL_WIDTH-1:0] pin_levels;
    logic                   out_valid;
    logic                   out_stall;
    logic [DATA_WIDTH-1:0]  read_data;
    logic [LEVEL_WIDTH-1:0] output_levels;

    logic [FSEL_WIDTH-1:0]  fsel_shadow [FSEL_WORDS] = '{default: '0};
    logic [PIN_SPACE-1:0]   latch_shadow = '0;
    gpio_result_t           expected_results [$];
    int                     mismatch_count = 0;
    int                     send_idle_pct;
    int                     recv_idle_pct;

    gpio_register_block #(
        .PIN_COUNT(PIN_COUNT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .word_address(word_address),
        .write_data(write_data),
        .pin_levels(pin_levels),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .output_levels(output_levels)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [PIN_SPACE-1:0] pin_space_mask();
        if (PIN_COUNT >= PIN_SPACE)
        begin
            return '1;
        end
        return (64'd1 << PIN_COUNT) - 64'd1;
    endfunction

    function automatic logic [FSEL_WIDTH-1:0] select_field_mask(input int widx);
        logic [FSEL_WIDTH-1:0] m;
        m = '0;
        for (int f = 0; f < PINS_PER_FSEL; f++)
        begin
            if (widx * PINS_PER_FSEL + f < PIN_COUNT)
            begin
                m[3*f +: 3] = 3'b111;
            end
        end
        return m;
    endfunction

    function automatic gpio_result_t predict_access(input logic cmd,
                                                    input logic [ADDR_WIDTH-1:0] addr,
                                                    input logic [DATA_WIDTH-1:0] data,
                                                    input logic [LEVEL_WIDTH-1:0] levels);
        gpio_result_t         r;
        logic [PIN_SPACE-1:0] pins;
        logic [PIN_SPACE-1:0] sampled;
        r.read_data = '0;
        pins = (addr == ADDR_SET_HI || addr == ADDR_CLR_HI) ? {data, 32'd0} : {32'd0, data};
        pins = pins & pin_space_mask();
        sampled = PIN_SPACE'(levels) & pin_space_mask();
        if (addr < FSEL_WORDS)
        begin
            if (cmd == CMD_WRITE)
            begin
                fsel_shadow[addr[2:0]] = data[FSEL_WIDTH-1:0] & select_field_mask(int'(addr));
            end
            else
            begin
                r.read_data = DATA_WIDTH'(fsel_shadow[addr[2:0]]);
            end
        end
        else
        begin
            case (addr)
                ADDR_SET_LO, ADDR_SET_HI:
                begin
                    if (cmd == CMD_WRITE)
                    begin
                        latch_shadow = latch_shadow | pins;
                    end
                end
                ADDR_CLR_LO, ADDR_CLR_HI:
                begin
                    if (cmd == CMD_WRITE)
                    begin
                        latch_shadow = latch_shadow & ~pins;
                    end
                end
                ADDR_LEV_LO:
                begin
                    if (cmd == CMD_READ)
                    begin
                        r.read_data = sampled[31:0];
                    end
                end
                ADDR_LEV_HI:
                begin
                    if (cmd == CMD_READ)
                    begin
                        r.read_data = sampled[63:32];
                    end
                end
                default:
                begin
                end
            endcase
        end
        latch_shadow = latch_shadow & pin_space_mask();
        r.output_levels = latch_shadow[LEVEL_WIDTH-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        gpio_result_t want;
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result read_data=%h output_levels=%h",
                                          read_data, output_levels));
            end
            else
            begin
                want = expected_results.pop_front();
                if (read_data !== want.read_data)
                begin
                    report_mismatch($sformatf("read_data got %h expected %h",
                                              read_data, want.read_data));
                end
                if (output_levels !== want.output_levels)
                begin
                    report_mismatch($sformatf("output_levels got %h expected %h",
                                              output_levels, want.output_levels));
                end
            end
        end
        if (in_valid && !in_stall)
        begin
            expected_results.push_back(predict_access(command, word_address,
                                                      write_data, pin_levels));
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic send_access(input logic cmd, input logic [ADDR_WIDTH-1:0] addr,
                               input logic [DATA_WIDTH-1:0] data,
                               input logic [LEVEL_WIDTH-1:0] levels);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        word_address <= addr;
        write_data   <= data;
        pin_levels   <= levels;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic test_function_select();
        send_access(CMD_WRITE, ADDR_FSEL0, '1, '0);
        send_access(CMD_WRITE, ADDR_FSEL5, '1, '0);
        send_access(CMD_READ,  ADDR_FSEL0, '0, '0);
        send_access(CMD_READ,  ADDR_FSEL5, '0, '0);
        send_access(CMD_WRITE, ADDR_FSEL3, 32'hAAAA_AAAA, '0);
        send_access(CMD_READ,  ADDR_FSEL3, '0, '1);
        send_access(CMD_WRITE, ADDR_FSEL5, '0, '0);
        send_access(CMD_READ,  ADDR_FSEL5, '1, '0);
    endtask

    task automatic test_set_clear();
        send_access(CMD_WRITE, ADDR_SET_LO, '1, '0);
        send_access(CMD_WRITE, ADDR_SET_HI, '1, '0);
        send_access(CMD_READ,  ADDR_SET_LO, '1, '0);
        send_access(CMD_WRITE, ADDR_CLR_LO, 32'h5555_5555, '0);
        send_access(CMD_WRITE, ADDR_CLR_HI, '1, '0);
        send_access(CMD_READ,  ADDR_CLR_HI, '0, '0);
        send_access(CMD_WRITE, ADDR_SET_HI, 32'h0020_0001, '0);
    endtask

    task automatic test_pin_levels();
        send_access(CMD_READ,  ADDR_LEV_LO, '0, '1);
        send_access(CMD_READ,  ADDR_LEV_HI, '0, '1);
        send_access(CMD_READ,  ADDR_LEV_LO, '1, '0);
        send_access(CMD_WRITE, ADDR_LEV_HI, '1, '1);
    endtask

    task automatic test_unmapped_words();
        send_access(CMD_WRITE, ADDR_GAP_FSEL, '1, '1);
        send_access(CMD_READ,  ADDR_GAP_FSEL, '0, '1);
        send_access(CMD_WRITE, ADDR_GAP_LEV, '1, '0);
        send_access(CMD_READ,  ADDR_GAP_SET, '0, '1);
        send_access(CMD_READ,  ADDR_GAP_CLR, '0, '1);
    endtask

    task automatic run_random_accesses(input int count);
        logic [DATA_WIDTH-1:0] data;
        logic [PIN_SPACE-1:0]  levels;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 7))
                0: data = '0;
                1: data = '1;
                default: data = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0: levels = '0;
                1: levels = '1;
                default: levels = {$urandom, $urandom};
            endcase
            send_access(1'($urandom_range(0, 1)), ADDR_WIDTH'($urandom_range(0, 15)), data,
                        levels[LEVEL_WIDTH-1:0]);
        end
    endtask

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_READ;
        word_address  = ADDR_FSEL0;
        write_data    = '0;
        pin_levels    = '0;
        send_idle_pct = 13;
        recv_idle_pct = 87;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_function_select();
        test_set_clear();
        test_pin_levels();
        test_unmapped_words();
        run_random_accesses(170);
        drain_results();

        send_idle_pct = 87;
        recv_idle_pct = 13;
        run_random_accesses(170);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_accesses(160);
        drain_results();

        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
